// ===== src/atc_pkg.sv =====
// shared types, widths and constants of the angle to rgb colour pipeline
`timescale 1ns / 1ps

package atc_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int COLOR_BITS = 16;

	// hue path widths
	localparam int DEG_W = 8;
	localparam int HUE_W = 9;
	localparam int K_W   = 6;

	// numerator widths: n < 32A, 2n and s2 < 64A, every numerator <= 1200A
	localparam int N_W   = ANGLE_BITS + 5;
	localparam int M_W   = ANGLE_BITS + 6;
	localparam int NUM_W = ANGLE_BITS + 11;

	// rounding divide by 1200A: shift by A*16, then divide by 75
	localparam int QUOT_W  = COLOR_BITS + 7;
	localparam int RECIP_W = COLOR_BITS + 1;
	localparam int REM_W   = 8;
	localparam int DIV_75  = 75;
	localparam logic [RECIP_W-1:0] RECIP_75 = RECIP_W'((64'd1 << QUOT_W) / DIV_75);

	localparam int HALF_TURN_DEG = 180;
	localparam int SECTOR_DEG    = 60;

	localparam int PIPE_LATENCY = 7;

	localparam int CHAN_R = 0;
	localparam int CHAN_G = 1;
	localparam int CHAN_B = 2;

	typedef enum logic [2:0] {
		SEC_R_Y,
		SEC_Y_G,
		SEC_G_C,
		SEC_C_B,
		SEC_B_M,
		SEC_M_R
	} sector_t;

	typedef struct packed {
		logic        [ANGLE_BITS-1:0] polar_angle;
		logic signed [ANGLE_BITS-1:0] azimuth_angle;
	} angles_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} color_t;

	typedef struct packed {
		logic                  dark;
		sector_t               sector;
		logic [K_W-1:0]        k;
		logic [ANGLE_BITS-1:0] pol;
	} hue_info_t;

	typedef logic [2:0][NUM_W-1:0] num_set_t;

endpackage

// ===== src/atc_hue.sv =====
// hue stages: azimuth to whole degrees, then sector and offset within sector
`timescale 1ns / 1ps

module atc_hue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  atc_pkg::angles_t   angles,
	output logic               out_valid,
	output atc_pkg::hue_info_t info
);

	localparam int AB = atc_pkg::ANGLE_BITS;
	localparam int DW = atc_pkg::DEG_W;
	localparam int HW = atc_pkg::HUE_W;
	localparam int KW = atc_pkg::K_W;
	localparam int PW = AB + DW;

	localparam logic [DW-1:0] DEG_HALF = DW'(atc_pkg::HALF_TURN_DEG);
	localparam logic [HW-1:0] HUE_HALF = HW'(atc_pkg::HALF_TURN_DEG);
	localparam logic [HW-1:0] START1   = HW'(1 * atc_pkg::SECTOR_DEG);
	localparam logic [HW-1:0] START2   = HW'(2 * atc_pkg::SECTOR_DEG);
	localparam logic [HW-1:0] START3   = HW'(3 * atc_pkg::SECTOR_DEG);
	localparam logic [HW-1:0] START4   = HW'(4 * atc_pkg::SECTOR_DEG);
	localparam logic [HW-1:0] START5   = HW'(5 * atc_pkg::SECTOR_DEG);

	logic [AB-1:0] az;
	logic          neg;
	logic [AB-1:0] mag;
	logic [PW-1:0] deg_prod;

	logic [DW-1:0] deg_s1;
	logic          neg_s1;
	logic [AB-1:0] pol_s1;
	logic          valid_s1;

	logic [HW-1:0]      hue;
	logic [HW-1:0]      base;
	atc_pkg::sector_t   sector;
	atc_pkg::hue_info_t info_s2;
	logic               valid_s2;

	// magnitude of the azimuth, degrees truncate toward zero
	always_comb begin
		az       = angles.azimuth_angle;
		neg      = az[AB-1];
		mag      = neg ? (~az + AB'(1)) : az;
		deg_prod = PW'(mag) * PW'(DEG_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		deg_s1 <= deg_prod[AB-1 +: DW];
		neg_s1 <= neg;
		pol_s1 <= angles.polar_angle;
	end

	always_comb begin
		hue = neg_s1 ? (HUE_HALF - HW'(deg_s1)) : (HUE_HALF + HW'(deg_s1));
		if (hue >= START5) begin
			sector = atc_pkg::SEC_M_R;
			base   = START5;
		end else if (hue >= START4) begin
			sector = atc_pkg::SEC_B_M;
			base   = START4;
		end else if (hue >= START3) begin
			sector = atc_pkg::SEC_C_B;
			base   = START3;
		end else if (hue >= START2) begin
			sector = atc_pkg::SEC_G_C;
			base   = START2;
		end else if (hue >= START1) begin
			sector = atc_pkg::SEC_Y_G;
			base   = START1;
		end else begin
			sector = atc_pkg::SEC_R_Y;
			base   = '0;
		end
	end

	always_ff @(posedge clk) begin
		info_s2.sector <= sector;
		info_s2.k      <= KW'(hue - base);
		// lightness below one half exactly when theta is below pi/2
		info_s2.dark   <= ~pol_s1[AB-1];
		info_s2.pol    <= pol_s1;
	end

	assign out_valid = valid_s2;
	assign info      = info_s2;

endmodule

// ===== src/atc_num.sv =====
// numerator stages: value and ramp numerators over 1200A, then sector routing
`timescale 1ns / 1ps

module atc_num (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  atc_pkg::hue_info_t info,
	output logic               out_valid,
	output atc_pkg::num_set_t  num
);

	localparam int AB  = atc_pkg::ANGLE_BITS;
	localparam int NW  = atc_pkg::N_W;
	localparam int MW  = atc_pkg::M_W;
	localparam int KW  = atc_pkg::K_W;
	localparam int UW  = atc_pkg::NUM_W;
	localparam int PW  = MW + KW;

	localparam logic [NW-1:0] A_ONE  = NW'(1) << AB;
	localparam logic [MW-1:0] A_38   = MW'(38) << AB;
	localparam logic [UW-1:0] DEN60  = UW'(1200) << AB;
	localparam logic [KW-1:0] SPAN   = KW'(atc_pkg::SECTOR_DEG);
	localparam logic [AB:0]   A_WIDE = (AB + 1)'(1) << AB;

	logic [NW-1:0] n;
	logic [MW-1:0] s2;
	logic [MW-1:0] m;
	logic [PW-1:0] pa_full;
	logic [PW-1:0] pb_full;
	logic [AB:0]   bright_ofs;

	logic [UW-1:0]    pa_s3;
	logic [UW-1:0]    pb_s3;
	logic [UW-1:0]    nv_s3;
	logic [UW-1:0]    np_s3;
	logic             dark_s3;
	atc_pkg::sector_t sector_s3;
	logic             valid_s3;

	logic [UW-1:0]     nq;
	logic [UW-1:0]     nt;
	atc_pkg::num_set_t num_c;
	atc_pkg::num_set_t num_s4;
	logic              valid_s4;

	// n = A + 18P, s2 = 2(19A - 18P); ramps share one pair of multipliers
	always_comb begin
		n          = A_ONE + NW'(info.pol) * NW'(18);
		s2         = A_38 - MW'(info.pol) * MW'(36);
		m          = info.dark ? {n, 1'b0} : s2;
		pa_full    = PW'(m) * PW'(info.k);
		pb_full    = PW'(m) * PW'(SPAN - info.k);
		bright_ofs = {info.pol, 1'b0} - A_WIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		pa_s3     <= pa_full[UW-1:0];
		pb_s3     <= pb_full[UW-1:0];
		nv_s3     <= info.dark ? UW'(n) * UW'(120) : DEN60;
		np_s3     <= info.dark ? '0 : UW'(bright_ofs) * UW'(1080);
		dark_s3   <= info.dark;
		sector_s3 <= info.sector;
	end

	always_comb begin
		nq = dark_s3 ? pb_s3 : (DEN60 - pa_s3);
		nt = dark_s3 ? pa_s3 : (DEN60 - pb_s3);
		case (sector_s3)
			atc_pkg::SEC_R_Y: begin
				num_c[atc_pkg::CHAN_R] = nv_s3;
				num_c[atc_pkg::CHAN_G] = nt;
				num_c[atc_pkg::CHAN_B] = np_s3;
			end
			atc_pkg::SEC_Y_G: begin
				num_c[atc_pkg::CHAN_R] = nq;
				num_c[atc_pkg::CHAN_G] = nv_s3;
				num_c[atc_pkg::CHAN_B] = np_s3;
			end
			atc_pkg::SEC_G_C: begin
				num_c[atc_pkg::CHAN_R] = np_s3;
				num_c[atc_pkg::CHAN_G] = nv_s3;
				num_c[atc_pkg::CHAN_B] = nt;
			end
			atc_pkg::SEC_C_B: begin
				num_c[atc_pkg::CHAN_R] = np_s3;
				num_c[atc_pkg::CHAN_G] = nq;
				num_c[atc_pkg::CHAN_B] = nv_s3;
			end
			atc_pkg::SEC_B_M: begin
				num_c[atc_pkg::CHAN_R] = nt;
				num_c[atc_pkg::CHAN_G] = np_s3;
				num_c[atc_pkg::CHAN_B] = nv_s3;
			end
			atc_pkg::SEC_M_R: begin
				num_c[atc_pkg::CHAN_R] = nv_s3;
				num_c[atc_pkg::CHAN_G] = np_s3;
				num_c[atc_pkg::CHAN_B] = nq;
			end
			default: begin
				num_c[atc_pkg::CHAN_R] = nv_s3;
				num_c[atc_pkg::CHAN_G] = nt;
				num_c[atc_pkg::CHAN_B] = np_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		num_s4 <= num_c;
	end

	assign out_valid = valid_s4;
	assign num       = num_s4;

endmodule

// ===== src/atc_scale.sv =====
// scaling stages: round each numerator over 1200A to a saturated colour code
`timescale 1ns / 1ps

module atc_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  atc_pkg::num_set_t num,
	output logic              out_valid,
	output atc_pkg::color_t   color
);

	localparam int AB = atc_pkg::ANGLE_BITS;
	localparam int CB = atc_pkg::COLOR_BITS;
	localparam int UW = atc_pkg::NUM_W;
	localparam int QW = atc_pkg::QUOT_W;
	localparam int RW = atc_pkg::RECIP_W;
	localparam int EW = atc_pkg::REM_W;
	localparam int SW = UW + CB;
	localparam int XW = QW + RW;

	localparam logic [SW-1:0] ROUND_HALF = SW'(600) << AB;
	localparam logic [QW-1:0] DIV_Q      = QW'(atc_pkg::DIV_75);
	localparam logic [EW-1:0] DIV_E      = EW'(atc_pkg::DIV_75);

	logic [2:0][CB-1:0] chan_c;
	logic [2:0][CB-1:0] chan_s7;
	logic               valid_s5;
	logic               valid_s6;
	logic               valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [SW-1:0] sum;
		logic [QW-1:0] t_s5;
		logic [QW-1:0] t_s6;
		logic [XW-1:0] prod_s6;
		logic [RW-1:0] q0;
		logic [QW-1:0] back;
		logic [QW-1:0] diff;
		logic [RW-1:0] q;

		// add half the divisor, drop the power of two part (16A) of 1200A
		assign sum = {num[i], {CB{1'b0}}} + ROUND_HALF;

		always_ff @(posedge clk) begin
			t_s5 <= sum[AB + 4 +: QW];
		end

		always_ff @(posedge clk) begin
			prod_s6 <= XW'(t_s5) * XW'(atc_pkg::RECIP_75);
			t_s6    <= t_s5;
		end

		// reciprocal estimate is low by at most one
		always_comb begin
			q0   = prod_s6[QW +: RW];
			back = QW'(q0) * DIV_Q;
			diff = t_s6 - back;
			q    = (diff[EW-1:0] >= DIV_E) ? (q0 + RW'(1)) : q0;
		end

		assign chan_c[i] = q[CB] ? {CB{1'b1}} : q[CB-1:0];
	end

	always_ff @(posedge clk) begin
		chan_s7 <= chan_c;
	end

	assign out_valid   = valid_s7;
	assign color.red   = chan_s7[atc_pkg::CHAN_R];
	assign color.green = chan_s7[atc_pkg::CHAN_G];
	assign color.blue  = chan_s7[atc_pkg::CHAN_B];

endmodule

// ===== src/angle_to_rgb_color_unit.sv =====
// top level: polar and azimuth angles to an rgb colour through a seven-stage pipeline
// throughput: one transfer per clock, set by the seven register stages that all advance every cycle
// busy is held low, as results are never held off and no stage waits on another
// reset: arst_n clears the stage valid bits only, data path registers keep whatever they hold
`timescale 1ns / 1ps

module angle_to_rgb_color_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  atc_pkg::angles_t angles,
	output logic             done,
	output atc_pkg::color_t  color
);

	localparam int AB  = atc_pkg::ANGLE_BITS;
	localparam int CB  = atc_pkg::COLOR_BITS;
	localparam int LAT = atc_pkg::PIPE_LATENCY;

	localparam logic [CB-1:0] FULL = {CB{1'b1}};

	logic               accept;
	logic               hue_valid;
	atc_pkg::hue_info_t hue_info;
	logic               num_valid;
	atc_pkg::num_set_t  num_set;

	// every stage moves on each clock, so a new transfer can always be taken
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// stages 1 and 2: degrees of azimuth, sector and offset, dark or bright half
	atc_hue u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angles    (angles),
		.out_valid (hue_valid),
		.info      (hue_info)
	);

	// stages 3 and 4: hsv numerators over a common denominator, routed per sector
	atc_num u_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.info      (hue_info),
		.out_valid (num_valid),
		.num       (num_set)
	);

	// stages 5 to 7: rounding divide by the common denominator and saturation
	atc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num_valid),
		.num       (num_set),
		.out_valid (done),
		.color     (color)
	);

`ifndef SYNTHESIS
	// a colour only ever follows an accepted transfer
	a_done_follows_start : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("colour strobe without an accepted transfer");

	// bright half: value is one, so some channel is at full scale
	a_bright_has_full : assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(accept && angles.polar_angle[AB-1], LAT)) |->
			(color.red == FULL || color.green == FULL || color.blue == FULL))
		else $error("bright colour without a full scale channel");

	// dark half: saturation is one, so some channel is zero
	a_dark_has_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(accept && !angles.polar_angle[AB-1], LAT)) |->
			(color.red == '0 || color.green == '0 || color.blue == '0))
		else $error("dark colour without a zero channel");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the angle to rgb colour unit
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 490;
	localparam int AB = atc_pkg::ANGLE_BITS;
	localparam int CB = atc_pkg::COLOR_BITS;
	localparam logic [63:0] ANGLE_ONE = 64'd1 << AB;
	localparam logic [63:0] COLOR_MAX = (64'd1 << CB) - 64'd1;

	// scoreboard: works out the colour of every accepted transfer and
	// checks the results strictly in order
	class colour_scoreboard;
		atc_pkg::color_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// rounds num/den60 to the colour scale, saturating at full intensity
		function logic [CB-1:0] to_intensity(logic [63:0] num, logic [63:0] den60);
			logic [63:0] y;
			y = (num * (64'd1 << (CB + 1)) + den60) / (64'd2 * den60);
			return (y > COLOR_MAX) ? COLOR_MAX[CB-1:0] : y[CB-1:0];
		endfunction

		function atc_pkg::color_t predict_colour(atc_pkg::angles_t a);
			logic [63:0] pol, az, mag, deg, hue, k;
			logic [63:0] n, dn, den60, s2;
			logic [63:0] nv, np, nq, nt, r, g, b;
			logic neg;
			atc_pkg::sector_t sec;
			atc_pkg::color_t c;
			pol = 64'(a.polar_angle);
			az = 64'(unsigned'(a.azimuth_angle));
			// degrees truncate toward zero, so small negatives land on 180
			neg = az[AB-1];
			mag = neg ? (ANGLE_ONE - az) : az;
			deg = (mag * atc_pkg::HALF_TURN_DEG) >> (AB - 1);
			hue = neg ? (atc_pkg::HALF_TURN_DEG - deg) : (atc_pkg::HALF_TURN_DEG + deg);
			sec = atc_pkg::sector_t'(3'(hue / atc_pkg::SECTOR_DEG));
			k = hue % atc_pkg::SECTOR_DEG;
			// lightness as n/dn, everything scaled by 60 for the sector split
			n = ANGLE_ONE + 64'd18 * pol;
			dn = 64'd20 * ANGLE_ONE;
			den60 = 64'd60 * dn;
			if (64'd2 * n < dn) begin
				nv = 64'd120 * n;
				np = 64'd0;
				nq = 64'd2 * n * (64'd60 - k);
				nt = 64'd2 * n * k;
			end else begin
				s2 = 64'd2 * (dn - n);
				nv = den60;
				np = 64'd60 * (64'd2 * n - dn);
				nq = den60 - s2 * k;
				nt = den60 - s2 * (64'd60 - k);
			end
			case (sec)
				atc_pkg::SEC_Y_G: begin r = nq; g = nv; b = np; end
				atc_pkg::SEC_G_C: begin r = np; g = nv; b = nt; end
				atc_pkg::SEC_C_B: begin r = np; g = nq; b = nv; end
				atc_pkg::SEC_B_M: begin r = nt; g = np; b = nv; end
				atc_pkg::SEC_M_R: begin r = nv; g = np; b = nq; end
				default: begin r = nv; g = nt; b = np; end
			endcase
			c.red = to_intensity(r, den60);
			c.green = to_intensity(g, den60);
			c.blue = to_intensity(b, den60);
			return c;
		endfunction

		function void note_angles(atc_pkg::angles_t a);
			expected_q = {expected_q, predict_colour(a)};
		endfunction

		function void check_colour(atc_pkg::color_t got);
			atc_pkg::color_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: colour %h with no transfer outstanding", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red) begin
				$display("%0t: red expected %h actual %h", $time, want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green expected %h actual %h", $time, want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	atc_pkg::angles_t angles;
	logic done;
	atc_pkg::color_t color;

	colour_scoreboard sb;
	int sender_idle_pct;
	int quiet_cycles;

	angle_to_rgb_color_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angles(angles),
		.done(done),
		.color(color)
	);

	// 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// monitor: the transfer and the result are both taken at the rising edge,
	// reading the values that held during the cycle before it
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_angles(angles);
			if (done)
				sb.check_colour(color);
		end
	end

	// watchdog: a long stretch with neither a transfer nor a result means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// presents one transfer, with random idle cycles in front of it;
	// busy is looked at on the falling edge, well clear of the driving edge
	task automatic send_angles(atc_pkg::angles_t a);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		angles <= a;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// sender holds off until every outstanding colour has come back
	task automatic drain_pipeline();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic atc_pkg::angles_t make_angles(int pol, int az);
		atc_pkg::angles_t a;
		a.polar_angle = pol[AB-1:0];
		a.azimuth_angle = az[AB-1:0];
		return a;
	endfunction

	// random transfers, weighted toward the lightness split, the ends of the
	// polar range and the sector edges of the hue
	function automatic atc_pkg::angles_t random_angles();
		int pol, az, edge_mag;
		pol = $urandom_range(65535);
		az = $urandom_range(65535);
		case ($urandom_range(3))
			1: pol = 32768 + $urandom_range(16) - 8;
			2: pol = $urandom_range(1) ? $urandom_range(3) : 65532 + $urandom_range(3);
			3: begin
				case ($urandom_range(3))
					0: edge_mag = 10923;
					1: edge_mag = 21845;
					2: edge_mag = 32767;
					default: edge_mag = 0;
				endcase
				az = edge_mag + $urandom_range(8) - 4;
				if ($urandom_range(1))
					az = -az;
			end
			default: ;
		endcase
		return make_angles(pol, az);
	endfunction

	int pol_pick[4] = '{0, 32767, 32768, 65535};
	int az_pick[10] = '{-32768, -1, 0, 32767, -27307, -16384, -5461, 5461, 16384, 27307};
	int phase_idle[4] = '{0, 46, 29, 0};

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		angles = '0;
		sender_idle_pct = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every sector, the hue wrap, the truncation at small
		// negative azimuth and both sides of the lightness split
		foreach (az_pick[i])
			send_angles(make_angles(pol_pick[i % 4], az_pick[i]));
		foreach (pol_pick[i]) begin
			send_angles(make_angles(pol_pick[i], -32768));
			send_angles(make_angles(pol_pick[i], -1));
		end
		send_angles(make_angles(65535, 32767));
		send_angles(make_angles(0, -32768));
		drain_pipeline();

		// random phases, each with its own sender idle rate; the unit cannot
		// stall its results, so only the sender side idles
		foreach (phase_idle[p]) begin
			sender_idle_pct = phase_idle[p];
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_angles(random_angles());
			drain_pipeline();
		end

		// let anything stray come out of the pipe before judging
		repeat (atc_pkg::PIPE_LATENCY + 4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/atc_pkg.sv
src/atc_hue.sv
src/atc_num.sv
src/atc_scale.sv
src/angle_to_rgb_color_unit.sv
dv/tb.sv
